FILE: hdl/mlp_pkg.sv
// Package for the 5-5-1 sigmoid perceptron: widths, fixed weights and biases,
// pipeline stage map, the per-layer rounding functions and the shared sigmoid.
// Depends on nothing; every other file of the block uses it.
package mlp_pkg;

  localparam int INPUT_COUNT    = 5;
  localparam int HIDDEN_COUNT   = 5;
  localparam int FEATURE_FIELDS = 5;

  localparam int FEAT_W   = 16;
  localparam int ACT_W    = 16;
  localparam int WEIGHT_W = 15;

  // Hidden layer: signed Q8.24 products and their sum with the bias.
  localparam int HPROD_W = FEAT_W + WEIGHT_W;
  localparam int HACC_W  = HPROD_W + $clog2(INPUT_COUNT + 1) + 1;

  // Output layer: unsigned Q4.28 products and their sum with the bias.
  localparam int OPROD_W = ACT_W + WEIGHT_W;
  localparam int OACC_W  = OPROD_W + $clog2(HIDDEN_COUNT + 1) + 1;

  // Pipeline stages, in order from input to output register.
  localparam int STG_HPROD = 0;
  localparam int STG_HSUM  = 1;
  localparam int STG_HACT  = 2;
  localparam int STG_OPROD = 3;
  localparam int STG_OSUM  = 4;
  localparam int STG_OACT  = 5;
  localparam int NSTAGE    = 6;

  typedef logic signed [FEAT_W-1:0] feature_t;
  typedef logic        [ACT_W-1:0]  act_t;

  // Load enables for the three stages of one layer.
  typedef struct packed {
    logic prod;
    logic sum;
    logic act;
  } pipe_en_t;

  // Q4.12 code of k/10, rounded to nearest.
  function automatic int tenth_q12(int k);
    return (k * 4096 + 5) / 10;
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] hid_weight(int i, int j);
    return WEIGHT_W'(tenth_q12(i + j + 1));
  endfunction

  function automatic logic signed [HACC_W-1:0] hid_bias(int i);
    return HACC_W'(tenth_q12(i + 1) * 4096);
  endfunction

  function automatic logic [WEIGHT_W-1:0] out_weight(int i);
    return WEIGHT_W'(tenth_q12(i + 1));
  endfunction

  function automatic logic [OACC_W-1:0] out_bias();
    return OACC_W'(tenth_q12(1)) << 16;
  endfunction

  // Q8.24 to Q4.12, half rounds upwards, saturated to 16 bits signed.
  function automatic feature_t round_sat_hid(logic signed [HACC_W-1:0] v);
    logic signed [HACC_W-1:0] r;
    r = (v + HACC_W'(2048)) >>> 12;
    if (r > HACC_W'(32767)) begin
      return 16'sh7FFF;
    end else if (r < -HACC_W'(32768)) begin
      return 16'sh8000;
    end else begin
      return r[FEAT_W-1:0];
    end
  endfunction

  // Q4.28 to Q4.12; the sum is never negative, so only the top needs a clamp.
  function automatic feature_t round_sat_out(logic [OACC_W-1:0] v);
    logic [OACC_W-1:0] r;
    r = (v + OACC_W'(32768)) >> 16;
    if (r > OACC_W'(32767)) begin
      return 16'sh7FFF;
    end else begin
      return r[FEAT_W-1:0];
    end
  endfunction

  // Piecewise-linear sigmoid, Q4.12 in, Q0.16 out, full scale reads as 65535.
  function automatic act_t sigmoid_q16(feature_t x);
    logic [FEAT_W:0] a;
    logic [FEAT_W:0] y;
    a = x[FEAT_W-1] ? (FEAT_W + 1)'(-$signed({x[FEAT_W-1], x})) : {1'b0, x};
    priority if (a >= 17'd20480) begin
      y = 17'd65536;
    end else if (a >= 17'd9728) begin
      y = (a >> 1) + 17'd55296;
    end else if (a >= 17'd4096) begin
      y = (a << 1) + 17'd40960;
    end else begin
      y = (a << 2) + 17'd32768;
    end
    if (x[FEAT_W-1]) begin
      y = 17'd65536 - y;
    end
    if (y[FEAT_W]) begin
      return 16'hFFFF;
    end else begin
      return y[ACT_W-1:0];
    end
  endfunction

endpackage

FILE: hdl/mlp_5_5_1_sigmoid_inference_unit.sv
// Top level of the 5-5-1 sigmoid perceptron: handshake, pipeline control
// and the hidden-layer lanes feeding the output merge stage.
// Depends on mlp_pkg, mlp_hidden_layer and mlp_output_merge.
//
// The block accepts one feature vector per clock cycle while in_ready_o is
// high and returns its probability through a six-stage pipeline: weight
// products, lane sums and hidden sigmoids for the five hidden lanes, then
// output products, output sum and the final sigmoid, whose register drives
// probability_o. Each stage moves on independently, so empty stages close
// up behind a stalled output and in_ready_o only falls once all six stages
// hold an item. The block keeps no state between items and needs no
// configuration.
module mlp_5_5_1_sigmoid_inference_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mlp_pkg::feature_t   feature_0_i,
  input  mlp_pkg::feature_t   feature_1_i,
  input  mlp_pkg::feature_t   feature_2_i,
  input  mlp_pkg::feature_t   feature_3_i,
  input  mlp_pkg::feature_t   feature_4_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mlp_pkg::act_t       probability_o
);

  logic [mlp_pkg::NSTAGE-1:0] valid_q;
  logic [mlp_pkg::NSTAGE-1:0] valid_d;
  logic [mlp_pkg::NSTAGE:0]   ready;

  mlp_pkg::feature_t feat    [mlp_pkg::FEATURE_FIELDS];
  mlp_pkg::feature_t x       [mlp_pkg::INPUT_COUNT];
  mlp_pkg::act_t     hidden  [mlp_pkg::HIDDEN_COUNT];
  mlp_pkg::pipe_en_t hid_en;
  mlp_pkg::pipe_en_t out_en;

  assign feat[0] = feature_0_i;
  assign feat[1] = feature_1_i;
  assign feat[2] = feature_2_i;
  assign feat[3] = feature_3_i;
  assign feat[4] = feature_4_i;

  // Features beyond the fields on the port read as zero.
  for (genvar gj = 0; gj < mlp_pkg::INPUT_COUNT; gj++) begin : g_feat
    if (gj < mlp_pkg::FEATURE_FIELDS) begin : g_port
      assign x[gj] = feat[gj];
    end else begin : g_zero
      assign x[gj] = '0;
    end
  end

  // A stage can load when it is empty or its content moves on this cycle.
  always_comb begin
    ready[mlp_pkg::NSTAGE] = out_ready_i;
    for (int k = mlp_pkg::NSTAGE - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  always_comb begin
    valid_d[0] = ready[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < mlp_pkg::NSTAGE; k++) begin
      if (ready[k]) begin
        valid_d[k] = valid_q[k-1];
      end else begin
        valid_d[k] = valid_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign hid_en.prod = ready[mlp_pkg::STG_HPROD];
  assign hid_en.sum  = ready[mlp_pkg::STG_HSUM];
  assign hid_en.act  = ready[mlp_pkg::STG_HACT];
  assign out_en.prod = ready[mlp_pkg::STG_OPROD];
  assign out_en.sum  = ready[mlp_pkg::STG_OSUM];
  assign out_en.act  = ready[mlp_pkg::STG_OACT];

  mlp_hidden_layer u_hidden (
    .clk_i (clk_i),
    .en_i  (hid_en),
    .x_i   (x),
    .h_o   (hidden)
  );

  mlp_output_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (out_en),
    .h_i    (hidden),
    .prob_o (probability_o)
  );

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[mlp_pkg::STG_OACT];

endmodule

FILE: hdl/mlp_hidden_layer.sv
// Hidden layer: one lane per hidden neuron, each a constant dot product,
// bias, rounding and sigmoid over three pipeline stages.
// Depends on mlp_pkg.
module mlp_hidden_layer (
  input  logic                clk_i,
  input  mlp_pkg::pipe_en_t   en_i,
  input  mlp_pkg::feature_t   x_i [mlp_pkg::INPUT_COUNT],
  output mlp_pkg::act_t       h_o [mlp_pkg::HIDDEN_COUNT]
);

  logic signed [mlp_pkg::HPROD_W-1:0] prod_q [mlp_pkg::HIDDEN_COUNT][mlp_pkg::INPUT_COUNT];
  logic signed [mlp_pkg::HACC_W-1:0]  sum_d  [mlp_pkg::HIDDEN_COUNT];
  logic signed [mlp_pkg::HACC_W-1:0]  sum_q  [mlp_pkg::HIDDEN_COUNT];
  mlp_pkg::act_t                      h_q    [mlp_pkg::HIDDEN_COUNT];

  for (genvar gi = 0; gi < mlp_pkg::HIDDEN_COUNT; gi++) begin : g_lane
    for (genvar gj = 0; gj < mlp_pkg::INPUT_COUNT; gj++) begin : g_tap
      localparam logic signed [mlp_pkg::WEIGHT_W-1:0] W = mlp_pkg::hid_weight(gi, gj);

      always_ff @(posedge clk_i) begin
        if (en_i.prod) begin
          prod_q[gi][gj] <= mlp_pkg::HPROD_W'(x_i[gj] * W);
        end
      end
    end

    always_comb begin
      sum_d[gi] = mlp_pkg::hid_bias(gi);
      for (int j = 0; j < mlp_pkg::INPUT_COUNT; j++) begin
        sum_d[gi] = sum_d[gi] + mlp_pkg::HACC_W'(prod_q[gi][j]);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i.sum) begin
        sum_q[gi] <= sum_d[gi];
      end
      if (en_i.act) begin
        h_q[gi] <= mlp_pkg::sigmoid_q16(mlp_pkg::round_sat_hid(sum_q[gi]));
      end
    end

    assign h_o[gi] = h_q[gi];
  end

endmodule

FILE: hdl/mlp_output_merge.sv
// Output neuron: merges the hidden lanes through the output weights, adds
// the bias, rounds and applies the final sigmoid into the output register.
// Depends on mlp_pkg.
module mlp_output_merge (
  input  logic                clk_i,
  input  mlp_pkg::pipe_en_t   en_i,
  input  mlp_pkg::act_t       h_i [mlp_pkg::HIDDEN_COUNT],
  output mlp_pkg::act_t       prob_o
);

  logic [mlp_pkg::OPROD_W-1:0] prod_q [mlp_pkg::HIDDEN_COUNT];
  logic [mlp_pkg::OACC_W-1:0]  sum_d;
  logic [mlp_pkg::OACC_W-1:0]  sum_q;
  mlp_pkg::act_t               prob_q;

  for (genvar gi = 0; gi < mlp_pkg::HIDDEN_COUNT; gi++) begin : g_tap
    localparam logic [mlp_pkg::WEIGHT_W-1:0] W = mlp_pkg::out_weight(gi);

    always_ff @(posedge clk_i) begin
      if (en_i.prod) begin
        prod_q[gi] <= mlp_pkg::OPROD_W'(h_i[gi]) * mlp_pkg::OPROD_W'(W);
      end
    end
  end

  always_comb begin
    sum_d = mlp_pkg::out_bias();
    for (int i = 0; i < mlp_pkg::HIDDEN_COUNT; i++) begin
      sum_d = sum_d + mlp_pkg::OACC_W'(prod_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      sum_q <= sum_d;
    end
    if (en_i.act) begin
      prob_q <= mlp_pkg::sigmoid_q16(mlp_pkg::round_sat_out(sum_q));
    end
  end

  assign prob_o = prob_q;

endmodule

FILE: hdl/mlp_checker.sv
// Port-level checks for the perceptron top level, attached by bind.
// Depends on mlp_pkg and mlp_5_5_1_sigmoid_inference_unit.
module mlp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input mlp_pkg::act_t probability_o
);

  localparam int CNT_W = $clog2(mlp_pkg::NSTAGE + 2);

  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_d;
  logic             in_xfer;
  logic             out_xfer;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_xfer && !out_xfer) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (out_xfer && !in_xfer) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // With the output register empty, every stage behind it can take an item.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while the output register is empty");

  // A result is only offered for an item that has gone in.
  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != '0)
    else $error("result offered with no item in flight");

  // The pipeline holds no more items than it has stages.
  a_occupancy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(mlp_pkg::NSTAGE))
    else $error("more items in flight than pipeline stages");

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(probability_o))
    else $error("stalled result dropped or changed");

endmodule

bind mlp_5_5_1_sigmoid_inference_unit mlp_checker u_mlp_checker (.*);
